>>> hdl/fpmg_pkg.sv
// shared types and constants for the fixed-point mlp policy gate
// no dependencies
`default_nettype none
package fpmg_pkg;

  localparam int WEIGHT_FRAC_BITS_DEF  = 12;
  localparam int FEATURE_FRAC_BITS_DEF = 16;
  localparam int LOAD_FRAC_BITS        = 11;
  localparam int FEATURE_CAP_UNITS     = 16;
  localparam int BIG_WEIGHT            = 32767;
  localparam int MEM_BIAS_Q16          = 6554;

  localparam int FRAMES_W = 32;
  localparam int LOAD_W   = 32;
  localparam int CPUS_W   = 11;
  localparam int COUNT_W  = 2;
  localparam int S_DATA_W = 112;
  localparam int M_DATA_W = 8;

  typedef struct packed {
    logic health_scan;
    logic trim_footprint;
    logic reclaim_memory;
  } action_t;

endpackage
`default_nettype wire

>>> hdl/fpmg_core.sv
// three-stage datapath: threshold products, compares, action count
// depends on fpmg_pkg
`default_nettype none
module fpmg_core #(
  parameter int WEIGHT_FRAC_BITS  = fpmg_pkg::WEIGHT_FRAC_BITS_DEF,
  parameter int FEATURE_FRAC_BITS = fpmg_pkg::FEATURE_FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            en,
  input  wire logic                            in_valid,
  input  wire logic [fpmg_pkg::FRAMES_W-1:0]   mem_free,
  input  wire logic [fpmg_pkg::FRAMES_W-1:0]   mem_total,
  input  wire logic                            thermal_flag,
  input  wire logic [fpmg_pkg::LOAD_W-1:0]     load_avg_q11,
  input  wire logic [fpmg_pkg::CPUS_W-1:0]     cpus_online,
  output logic                                 out_valid,
  output fpmg_pkg::action_t                    act,
  output logic [fpmg_pkg::COUNT_W-1:0]         action_count
);

  localparam int F  = FEATURE_FRAC_BITS;
  localparam int W  = WEIGHT_FRAC_BITS;
  localparam int SH = F - fpmg_pkg::LOAD_FRAC_BITS;
  localparam int XW = fpmg_pkg::FRAMES_W + F;
  localparam int LW = fpmg_pkg::LOAD_W + SH;

  // smallest hidden activation that still gives a positive logit
  localparam longint T    = ((longint'(1) << W) + longint'(fpmg_pkg::BIG_WEIGHT) - 1)
                            / longint'(fpmg_pkg::BIG_WEIGHT);
  localparam longint ONE  = longint'(1) << F;
  localparam longint BIAS = (longint'(fpmg_pkg::MEM_BIAS_Q16) << F) >> 16;
  localparam longint C0   = BIAS - T + 1;
  localparam longint K    = ONE + T;
  localparam longint CAP  = longint'(fpmg_pkg::FEATURE_CAP_UNITS) << F;
  localparam logic ZERO_TOTAL_RECLAIM = (ONE + T <= BIAS);
  localparam logic THERMAL_ON = ((ONE >> 1) * longint'(fpmg_pkg::BIG_WEIGHT)
                                 >= (longint'(1) << W));
  localparam logic HIGH_LOAD_OK = (CAP >= K);

  localparam logic [XW-1:0] C0X = XW'(C0);
  localparam logic [LW-1:0] KX  = LW'(K);

  // stage 1
  logic          v1;
  logic [XW-1:0] a0;
  logic [XW-1:0] m0;
  logic          tz;
  logic          th1;
  logic [LW-1:0] a2;
  logic [LW-1:0] m2;
  logic          cz;
  // stage 2
  logic              v2;
  fpmg_pkg::action_t act2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0  <= {mem_free, {F{1'b0}}};
      m0  <= C0X * {{F{1'b0}}, mem_total};
      tz  <= (mem_total == '0);
      th1 <= thermal_flag;
      a2  <= {load_avg_q11, {SH{1'b0}}};
      m2  <= KX * {{(LW - fpmg_pkg::CPUS_W){1'b0}}, cpus_online};
      cz  <= (cpus_online == '0);

      act2.reclaim_memory <= tz ? ZERO_TOTAL_RECLAIM : (a0 < m0);
      act2.trim_footprint <= th1 & THERMAL_ON;
      act2.health_scan    <= (th1 & THERMAL_ON) | (!cz & HIGH_LOAD_OK & (a2 >= m2));

      act <= act2;
      action_count <= {1'b0, act2.reclaim_memory} + {1'b0, act2.trim_footprint}
                      + {1'b0, act2.health_scan};
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> action_count == fpmg_pkg::COUNT_W'($countones(act)))
    else $error("action count mismatch");
  a_trim_health: assert property (@(posedge clk) disable iff (rst)
    out_valid && act.trim_footprint |-> act.health_scan)
    else $error("trim without health scan");
  a_reset: assert property (@(posedge clk) $past(rst) && !rst |-> !v1 && !v2 && !out_valid)
    else $error("valid after reset");

endmodule
`default_nettype wire

>>> hdl/fixed_point_mlp_policy_gate_top.sv
// top level of the load-policy gate: stream ports around the datapath
// depends on fpmg_pkg and fpmg_core
//
// Takes one load snapshot per item and returns one action item. The block
// accepts an item every cycle while the result side is not stalled; a
// result passes through the three register stages of fpmg_core (threshold
// products, compares, action count) before it is valid. A stalled result
// holds the whole pipeline.
`default_nettype none
module fixed_point_mlp_policy_gate_top #(
  parameter int WEIGHT_FRAC_BITS  = fpmg_pkg::WEIGHT_FRAC_BITS_DEF,
  parameter int FEATURE_FRAC_BITS = fpmg_pkg::FEATURE_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // mem_free, mem_total, thermal_flag, load_avg_q11, cpus_online
  input  wire logic [fpmg_pkg::S_DATA_W-1:0] s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // reclaim_memory, trim_footprint, health_scan, action_count
  output logic [fpmg_pkg::M_DATA_W-1:0]      m_axis_tdata
);

  logic                            en;
  fpmg_pkg::action_t               act;
  logic [fpmg_pkg::COUNT_W-1:0]    action_count;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  fpmg_core #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
    .FEATURE_FRAC_BITS(FEATURE_FRAC_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (s_axis_tvalid),
    .mem_free    (s_axis_tdata[31:0]),
    .mem_total   (s_axis_tdata[63:32]),
    .thermal_flag(s_axis_tdata[64]),
    .load_avg_q11(s_axis_tdata[96:65]),
    .cpus_online (s_axis_tdata[107:97]),
    .out_valid   (m_axis_tvalid),
    .act         (act),
    .action_count(action_count)
  );

  assign m_axis_tdata = {3'b000, action_count, act.health_scan, act.trim_footprint,
                         act.reclaim_memory};

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:5] == 3'b000)
    else $error("nonzero pad bits");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("not ready while output empty");
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[4:3] == 2'($countones(m_axis_tdata[2:0])))
    else $error("count mismatch at port");

endmodule
`default_nettype wire

>>> sim/fpmg_action_checker.sv
`timescale 1ns / 100ps
// scoreboard for the load-policy gate: predicts the action item for every accepted snapshot
// and compares it with the result stream; depends on fpmg_pkg
module fpmg_action_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  input  wire logic                          s_axis_tready,
  input  wire logic [fpmg_pkg::S_DATA_W-1:0] s_axis_tdata,
  input  wire logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic [fpmg_pkg::M_DATA_W-1:0] m_axis_tdata,
  output int                                 error_count,
  output int                                 pending_count
);

  localparam int FF = fpmg_pkg::FEATURE_FRAC_BITS_DEF;
  localparam int WF = fpmg_pkg::WEIGHT_FRAC_BITS_DEF;

  typedef struct packed {
    fpmg_pkg::action_t              acts;
    logic [fpmg_pkg::COUNT_W-1:0]   count;
  } decision_t;

  decision_t expected_decisions[$];

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint relu(longint x);
    return (x > 0) ? x : 0;
  endfunction

  function automatic decision_t predict_decision(logic [fpmg_pkg::S_DATA_W-1:0] d);
    longint unsigned mem_free, mem_total, load, cpus, q;
    longint f_mem, f_therm, f_load, h_mem, h_therm, h_load, l_mem, l_therm, l_load;
    decision_t r;
    mem_free  = d[31:0];
    mem_total = d[63:32];
    load      = d[96:65];
    cpus      = d[107:97];
    if (mem_total != 0) begin
      q = (mem_free << FF) / mem_total;
      f_mem = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
    end else begin
      f_mem = longint'(1) << FF;
    end
    f_therm = d[64] ? (longint'(1) << FF) : 0;
    if (cpus != 0) begin
      q = (load << (FF - fpmg_pkg::LOAD_FRAC_BITS)) / cpus;
      f_load = (q > (longint'(fpmg_pkg::FEATURE_CAP_UNITS) << FF))
        ? (longint'(fpmg_pkg::FEATURE_CAP_UNITS) << FF) : longint'(q);
    end else begin
      f_load = 0;
    end
    h_mem   = relu(sat32(sat32((-(longint'(1) << WF) * f_mem) >>> WF)
                 + ((longint'(fpmg_pkg::MEM_BIAS_Q16) << FF) >>> 16)));
    h_therm = relu(sat32(sat32(((longint'(1) << WF) * f_therm) >>> WF)
                 - (longint'(1) << (FF - 1))));
    h_load  = relu(sat32(sat32(((longint'(1) << WF) * f_load) >>> WF)
                 - (longint'(1) << FF)));
    l_mem   = sat32((fpmg_pkg::BIG_WEIGHT * h_mem) >>> WF);
    l_therm = sat32((fpmg_pkg::BIG_WEIGHT * h_therm) >>> WF);
    l_load  = sat32((fpmg_pkg::BIG_WEIGHT * (h_therm + h_load)) >>> WF);
    r.acts.reclaim_memory = l_mem > 0;
    r.acts.trim_footprint = l_therm > 0;
    r.acts.health_scan    = l_load > 0;
    r.count = r.acts.reclaim_memory + r.acts.trim_footprint + r.acts.health_scan;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    decision_t want;
    if (rst) begin
      expected_decisions.delete();
      error_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_decisions.size() == 0) begin
          report_mismatch("unexpected item, tdata", m_axis_tdata, 0);
        end else begin
          want = expected_decisions.pop_front();
          if (m_axis_tdata[0] !== want.acts.reclaim_memory)
            report_mismatch("reclaim_memory", m_axis_tdata[0], want.acts.reclaim_memory);
          if (m_axis_tdata[1] !== want.acts.trim_footprint)
            report_mismatch("trim_footprint", m_axis_tdata[1], want.acts.trim_footprint);
          if (m_axis_tdata[2] !== want.acts.health_scan)
            report_mismatch("health_scan", m_axis_tdata[2], want.acts.health_scan);
          if (m_axis_tdata[4:3] !== want.count)
            report_mismatch("action_count", m_axis_tdata[4:3], want.count);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_decisions.push_back(predict_decision(s_axis_tdata));
    end
    pending_count = expected_decisions.size();
  end
endmodule

>>> sim/tb_fixed_point_mlp_policy_gate_top.sv
`timescale 1ns / 100ps
// testbench top for the load-policy gate: clock, reset, snapshot stimulus and verdict
// depends on fpmg_pkg, fixed_point_mlp_policy_gate_top and fpmg_action_checker
module tb_fixed_point_mlp_policy_gate_top;

  localparam int RANDOM_SNAPSHOTS = 650;
  localparam int IDLE_LIMIT       = 20000;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [fpmg_pkg::S_DATA_W-1:0] s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [fpmg_pkg::M_DATA_W-1:0] m_axis_tdata;
  int                            error_count;
  int                            pending_count;
  int                            idle_cycles = 0;
  bit                            steady_ready = 1'b0;

  fixed_point_mlp_policy_gate_top u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  fpmg_action_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .error_count(error_count), .pending_count(pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result-side stalls, with stretches of steady ready
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready = 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) steady_ready = !steady_ready;
      if (steady_ready) m_axis_tready = 1'b1;
      else if ($urandom_range(0, 99) < 4) m_axis_tready = 1'b0;
      else if (!m_axis_tready) m_axis_tready = ($urandom_range(0, 3) == 0);
      else m_axis_tready = ($urandom_range(0, 9) != 0);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_snapshot(logic [31:0] mem_free, logic [31:0] mem_total,
                               logic thermal, logic [31:0] load, logic [10:0] cpus);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  = {4'b0, cpus, load, thermal, mem_total, mem_free};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic send_random_snapshot();
    logic [31:0] mem_free, mem_total, load;
    logic [10:0] cpus;
    int          kind;
    kind      = $urandom_range(0, 9);
    mem_total = $urandom();
    mem_free  = $urandom();
    load      = $urandom();
    cpus      = $urandom_range(0, 2047);
    if (kind < 4) begin
      // free fraction near the 0.1 threshold
      mem_total = $urandom_range(1, 32'hFFFF_FFFF) >> $urandom_range(0, 31);
      if (mem_total == 0) mem_total = 1;
      mem_free = mem_total / 10 + $urandom_range(0, 8) - 4;
      if (mem_free > mem_total) mem_free = mem_total;
    end else if (kind < 5) begin
      mem_total = 0;
    end
    if (kind >= 2 && kind < 7) begin
      // load per cpu near 1.0
      cpus = $urandom_range(1, 2047);
      load = cpus * 2048 + $urandom_range(0, 8) - 4;
    end else if (kind == 7) begin
      cpus = 0;
    end else if (kind == 8) begin
      cpus = $urandom_range(1, 8);
      load = load >> $urandom_range(0, 24);
    end
    send_snapshot(mem_free, mem_total, $urandom_range(0, 1), load, cpus);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    send_snapshot(32'd0, 32'd0, 1'b0, 32'd0, 11'd0);
    send_snapshot(32'hFFFF_FFFF, 32'd1, 1'b0, 32'd0, 11'd1);
    send_snapshot(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 11'd1);
    send_snapshot(32'd0, 32'hFFFF_FFFF, 1'b0, 32'd0, 11'd2047);
    send_snapshot(32'd6553, 32'd65536, 1'b0, 32'd0, 11'd4);
    send_snapshot(32'd6554, 32'd65536, 1'b0, 32'd0, 11'd4);
    send_snapshot(32'd6555, 32'd65536, 1'b1, 32'd0, 11'd4);
    send_snapshot(32'd5, 32'd3, 1'b0, 32'd2048, 11'd1);
    send_snapshot(32'd100, 32'd100, 1'b0, 32'd2049, 11'd1);
    send_snapshot(32'd100, 32'd100, 1'b0, 32'd2047, 11'd1);
    send_snapshot(32'd1, 32'd10, 1'b1, 32'hFFFF_FFFF, 11'd2047);
    send_snapshot(32'd1, 32'd10, 1'b0, 32'hFFFF_FFFF, 11'd0);
    send_snapshot(32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 32'h5555_5555, 11'h2AA);
    send_snapshot(32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'hAAAA_AAAA, 11'h555);
    send_snapshot(32'd0, 32'd1, 1'b0, 32'd4096, 11'd1024);
    send_snapshot(32'd7, 32'd0, 1'b1, 32'd2048, 11'd1025);
    for (int n = 0; n < RANDOM_SNAPSHOTS; n++) begin
      send_random_snapshot();
      if (n == RANDOM_SNAPSHOTS / 2) begin
        // drain the pipeline completely before going on
        s_axis_tvalid = 1'b0;
        while (pending_count != 0) @(negedge clk);
      end
    end
    s_axis_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
